// File: hdl/bmpd_pkg.sv
// Shared types, constants and the work item format of the 1 bpp bitmap decoder.
package bmpd_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;

   localparam logic [15:0] BMP_SIGNATURE = 16'h4D42;

   localparam int HDR_BYTES  = 30;
   localparam int SIG_POS    = 0;
   localparam int OFFSET_POS = 10;
   localparam int WIDTH_POS  = 18;
   localparam int HEIGHT_POS = 22;
   localparam int DEPTH_POS  = 28;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   typedef enum logic [1:0] {
      KIND_PIXEL   = 2'd0,
      KIND_BAD_SIG = 2'd1,
      KIND_TOO_BIG = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_SKIP   = 2'd1,
      PH_PIXELS = 2'd2,
      PH_DONE   = 2'd3
   } phase_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  data;
      logic [9:0]  x_base;
      logic [10:0] y;
      logic [3:0]  count;
   } work_item_type;

endpackage

// File: hdl/bmpd_front.sv
// Front end: parses the byte stream and turns each byte into at most one work item.
module bmpd_front import bmpd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          accept,
   input  logic [7:0]    data_byte,
   input  logic          file_start,
   input  logic [9:0]    row_offset,
   output logic          item_valid,
   output work_item_type item
);

   phase_type   phase_ff, phase_in, phase_cur;
   logic [31:0] count_ff, count_in, idx;
   logic [12:0] rbi_ff, rbi_in, rbi_cur, rbi_next;
   logic [10:0] row_ff, row_in, row_cur;
   logic [15:0] sig_ff, sig_in;
   logic [31:0] offset_ff, offset_in;
   logic [31:0] width_ff, width_in;
   logic [31:0] height_ff, height_in;
   logic [15:0] depth_ff, depth_in;
   logic [1:0]  off_lane, wid_lane, hgt_lane;
   logic        hdr_end, sig_bad, too_big, no_image, hdr_ok;
   logic        in_pix, row_end;
   logic [31:0] row_words;
   logic [13:0] row_size;
   logic [15:0] base;
   logic [31:0] remaining;
   logic        has_pixels;

   assign phase_cur = file_start ? PH_HEADER : phase_ff;
   assign idx       = file_start ? 32'd0 : count_ff;
   assign rbi_cur   = file_start ? 13'd0 : rbi_ff;
   assign row_cur   = file_start ? 11'd0 : row_ff;
   assign count_in  = accept ? ((&idx) ? idx : idx + 32'd1) : count_ff;

   assign off_lane = 2'(idx - 32'(OFFSET_POS));
   assign wid_lane = 2'(idx - 32'(WIDTH_POS));
   assign hgt_lane = 2'(idx - 32'(HEIGHT_POS));

   always_comb begin
      sig_in    = sig_ff;
      offset_in = offset_ff;
      width_in  = width_ff;
      height_in = height_ff;
      depth_in  = depth_ff;
      if (accept && phase_cur == PH_HEADER) begin
         if (idx < 32'(SIG_POS + 2)) begin
            sig_in[8*idx[0] +: 8] = data_byte;
         end else if (idx >= 32'(OFFSET_POS) && idx < 32'(OFFSET_POS + 4)) begin
            offset_in[8*off_lane +: 8] = data_byte;
         end else if (idx >= 32'(WIDTH_POS) && idx < 32'(WIDTH_POS + 4)) begin
            width_in[8*wid_lane +: 8] = data_byte;
         end else if (idx >= 32'(HEIGHT_POS) && idx < 32'(HEIGHT_POS + 4)) begin
            height_in[8*hgt_lane +: 8] = data_byte;
         end else if (idx >= 32'(DEPTH_POS) && idx < 32'(DEPTH_POS + 2)) begin
            depth_in[8*idx[0] +: 8] = data_byte;
         end
      end
   end

   assign hdr_end  = phase_cur == PH_HEADER && idx == 32'(HDR_BYTES - 1);
   assign sig_bad  = sig_in != BMP_SIGNATURE;
   assign too_big  = (!width_in[31] && width_in > 32'(MAX_WIDTH)) ||
                     (!height_in[31] && height_in > 32'(MAX_HEIGHT));
   assign no_image = width_in[31] || height_in[31] || width_in == 32'd0 ||
                     height_in == 32'd0 || depth_in != 16'd1;
   assign hdr_ok   = !sig_bad && !too_big && !no_image;

   assign in_pix    = phase_cur == PH_PIXELS ||
                      (phase_cur == PH_SKIP && idx >= offset_ff);
   assign row_words = (width_ff + 32'd31) >> 5;
   assign row_size  = {row_words[11:0], 2'b00};
   assign rbi_next  = rbi_cur + 13'd1;
   assign row_end   = {1'b0, rbi_next} >= row_size;

   assign base       = {rbi_cur, 3'b000};
   assign remaining  = width_ff - {16'd0, base};
   assign has_pixels = {16'd0, base} < width_ff;

   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         case (phase_cur)
            PH_HEADER: begin
               phase_in = PH_HEADER;
               if (hdr_end) begin
                  phase_in = hdr_ok ? PH_SKIP : PH_DONE;
               end
            end
            PH_SKIP, PH_PIXELS: begin
               if (!in_pix) begin
                  phase_in = PH_SKIP;
               end else if (row_end && row_cur == 11'd0) begin
                  phase_in = PH_DONE;
               end else begin
                  phase_in = PH_PIXELS;
               end
            end
            default: phase_in = PH_DONE;
         endcase
      end
   end

   always_comb begin
      rbi_in      = rbi_ff;
      row_in      = row_ff;
      item_valid  = 1'b0;
      item.kind   = KIND_PIXEL;
      item.data   = data_byte;
      item.x_base = base[9:0];
      item.y      = {1'b0, row_offset} + row_cur;
      item.count  = (remaining >= 32'd8) ? 4'd8 : remaining[3:0];
      if (accept) begin
         rbi_in = rbi_cur;
         row_in = row_cur;
         if (hdr_end) begin
            if (hdr_ok) begin
               rbi_in = 13'd0;
               row_in = height_in[10:0] - 11'd1;
            end
            if (sig_bad || too_big) begin
               item_valid  = 1'b1;
               item.kind   = sig_bad ? KIND_BAD_SIG : KIND_TOO_BIG;
               item.data   = 8'd0;
               item.x_base = 10'd0;
               item.y      = 11'd0;
               item.count  = 4'd1;
            end
         end else if (in_pix) begin
            item_valid = has_pixels;
            rbi_in     = row_end ? 13'd0 : rbi_next;
            if (row_end && row_cur != 11'd0) begin
               row_in = row_cur - 11'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         count_ff <= 32'd0;
         rbi_ff   <= 13'd0;
         row_ff   <= 11'd0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         rbi_ff   <= rbi_in;
         row_ff   <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      sig_ff    <= sig_in;
      offset_ff <= offset_in;
      width_ff  <= width_in;
      height_ff <= height_in;
      depth_ff  <= depth_in;
   end

endmodule

// File: hdl/bmpd_queue.sv
// Short work item queue between the parser and the pixel expander.
module bmpd_queue import bmpd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          wr_en,
   input  work_item_type wr_item,
   input  logic          rd_en,
   output logic          full,
   output logic          head_valid,
   output work_item_type head
);

   work_item_type     entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   fill_ff, fill_in;
   logic              do_wr, do_rd;

   assign full       = fill_ff == (QPTR_W + 1)'(QUEUE_DEPTH);
   assign head_valid = fill_ff != '0;
   assign head       = entry_ff[rd_ptr_ff];
   assign do_wr      = wr_en && !full;
   assign do_rd      = rd_en && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         entry_ff[wr_ptr_ff] <= wr_item;
      end
   end

endmodule

// File: hdl/bmpd_back.sv
// Back end: expands each work item into result transactions, one per cycle while out_pop is high.
module bmpd_back import bmpd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          head_valid,
   input  work_item_type head,
   output logic          head_pop,
   input  logic          out_pop,
   output logic          out_valid,
   output logic [1:0]    out_kind,
   output logic [9:0]    out_x,
   output logic [10:0]   out_y,
   output logic          out_white,
   output logic          out_last
);

   logic [2:0]  k_ff, k_in;
   logic        valid_ff, valid_in;
   logic [1:0]  kind_ff;
   logic [9:0]  x_ff;
   logic [10:0] y_ff;
   logic        white_ff, last_ff;
   logic        load, last_bit;

   assign load     = head_valid && (!valid_ff || out_pop);
   assign last_bit = {1'b0, k_ff} == head.count - 4'd1;
   assign head_pop = load && last_bit;

   always_comb begin
      k_in     = k_ff;
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
         k_in     = last_bit ? 3'd0 : k_ff + 3'd1;
      end else if (out_pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff     <= 3'd0;
         valid_ff <= 1'b0;
      end else begin
         k_ff     <= k_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff  <= head.kind;
         x_ff     <= head.x_base + {7'd0, k_ff};
         y_ff     <= head.y;
         white_ff <= head.data[3'd7 - k_ff];
         last_ff  <= last_bit;
      end
   end

   assign out_valid = valid_ff;
   assign out_kind  = kind_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_white = white_ff;
   assign out_last  = last_ff;

endmodule

// File: hdl/bmp_mono_pixel_decoder_top.sv
// Top level of the 1 bpp bitmap decoder: register port, parser, queue and pixel expander.
// The decoder takes one file byte per cycle while its four-entry work queue has room.
// Header, skipped and padding bytes yield no pixel transactions; a pixel data byte yields
// between one and eight pixel transactions, which the expander emits at one per cycle
// while the receiver keeps popping. Error transactions (bad signature, image too large)
// are single transactions with last set. The status bar height register lies at byte
// address 0.
module bmp_mono_pixel_decoder_top import bmpd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [7:0]  req_data_byte,
   input  logic        req_file_start,
   output logic        empty,
   input  logic        pop,
   output logic [1:0]  rsp_kind,
   output logic [9:0]  rsp_pixel_x,
   output logic [10:0] rsp_pixel_y,
   output logic        rsp_pixel_white,
   output logic        rsp_last,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [9:0]    sbh_ff, sbh_in;
   logic          accept, item_valid, head_valid, head_pop, out_valid;
   work_item_type item, head;

   assign pready = 1'b1;
   assign prdata = (paddr[2] == 1'b0) ? {22'd0, sbh_ff} : 32'd0;
   assign sbh_in = (psel && penable && pwrite && paddr[2] == 1'b0) ? pwdata[9:0] : sbh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sbh_ff <= 10'd0;
      end else begin
         sbh_ff <= sbh_in;
      end
   end

   assign accept = push && !full;
   assign empty  = !out_valid;

   bmpd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .data_byte  (req_data_byte),
      .file_start (req_file_start),
      .row_offset (sbh_ff),
      .item_valid (item_valid),
      .item       (item)
   );

   bmpd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (item_valid),
      .wr_item    (item),
      .rd_en      (head_pop),
      .full       (full),
      .head_valid (head_valid),
      .head       (head)
   );

   bmpd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .head_pop   (head_pop),
      .out_pop    (pop),
      .out_valid  (out_valid),
      .out_kind   (rsp_kind),
      .out_x      (rsp_pixel_x),
      .out_y      (rsp_pixel_y),
      .out_white  (rsp_pixel_white),
      .out_last   (rsp_last)
   );

`ifndef SYNTH
   a_error_is_last: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_kind != KIND_PIXEL) |-> rsp_last)
      else $error("error transaction without last");

   a_error_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_kind != KIND_PIXEL) |->
      (rsp_pixel_x == 10'd0 && rsp_pixel_y == 11'd0 && !rsp_pixel_white))
      else $error("error transaction carries pixel fields");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_pixel_x) && $stable(rsp_last)))
      else $error("waiting result changed before it was taken");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> (empty && !full))
      else $error("queues not empty after reset");
`endif

endmodule

// File: sim/tb_bmp_mono_pixel_decoder_top.sv
// Self-checking testbench of the 1 bpp bitmap decoder: directed files, random files and a predictor.
module tb_bmp_mono_pixel_decoder_top;
   import bmpd_pkg::*;

   localparam logic [2:0] CSR_STATUS_BAR = 3'd0;
   localparam int SETTLE_CYCLES = 24;
   localparam int CYCLE_LIMIT   = 800000;
   localparam int N_DIRECTED    = 16;
   localparam int PHASE_BYTES   = 16;

   typedef struct packed {
      kind_type    kind;
      logic [9:0]  x;
      logic [10:0] y;
      logic        white;
      logic        last;
   } decoded_type;

   typedef struct packed {
      logic [15:0] sig;
      logic [31:0] offs;
      logic [31:0] wid;
      logic [31:0] hgt;
      logic [15:0] dep;
      int          hdr_len;
      int          body;
      logic        start0;
      bit          typed;
      kind_type    kind;
   } file_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   logic [7:0]  req_data_byte = 8'd0;
   logic        req_file_start = 1'b0;
   logic        empty;
   logic        pop = 1'b0;
   logic [1:0]  rsp_kind;
   logic [9:0]  rsp_pixel_x;
   logic [10:0] rsp_pixel_y;
   logic        rsp_pixel_white;
   logic        rsp_last;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = 3'd0;
   logic [31:0] pwdata = 32'd0;
   logic [31:0] prdata;
   logic        pready;

   // Side information that travels with each byte: a header byte whose outcome is typed in.
   logic        byte_typed = 1'b0;
   kind_type    typed_kind = KIND_PIXEL;

   // Predictor state.
   phase_type   hdr_phase = PH_HEADER;
   logic [31:0] byte_pos_count = 32'd0;
   logic [15:0] sig_seen = 16'd0;
   logic [31:0] img_w = 32'd0;
   logic [31:0] img_h = 32'd0;
   logic [15:0] bits_pp = 16'd0;
   logic [31:0] data_start = 32'd0;
   logic [12:0] row_byte = 13'd0;
   logic [10:0] img_row = 11'd0;
   logic [9:0]  bar_height = 10'd0;

   decoded_type  decoded_queue [$];
   decoded_type  want_px;
   file_row_type directed_files [N_DIRECTED];

   int          fail_count = 0;
   int          transactions_checked = 0;
   int          bytes_parsed = 0;
   int          files_sent = 0;
   int          settings_used = 0;
   int          cycle_count = 0;
   int          burst_left = 0;
   bit          steady_sender = 1'b0;
   logic        push_level = 1'b0;

   bmp_mono_pixel_decoder_top u_top (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_data_byte   (req_data_byte),
      .req_file_start  (req_file_start),
      .empty           (empty),
      .pop             (pop),
      .rsp_kind        (rsp_kind),
      .rsp_pixel_x     (rsp_pixel_x),
      .rsp_pixel_y     (rsp_pixel_y),
      .rsp_pixel_white (rsp_pixel_white),
      .rsp_last        (rsp_last),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int decode_file_byte(input logic [7:0] b, input logic start,
                                           input bit keep);
      logic [31:0] pos;
      logic [31:0] row_len;
      logic [31:0] col;
      logic [10:0] yv;
      decoded_type batch [8];
      int          n;
      int          k;
      n = 0;
      if (start) begin
         hdr_phase = PH_HEADER;
         byte_pos_count = 32'd0;
         row_byte = 13'd0;
         img_row = 11'd0;
      end
      pos = byte_pos_count;
      if (byte_pos_count != 32'hFFFF_FFFF) byte_pos_count = byte_pos_count + 1;
      if (hdr_phase == PH_HEADER) begin
         if (pos < 2) sig_seen[8*pos[0] +: 8] = b;
         else if (pos >= 10 && pos < 14) data_start[8*(pos-10) +: 8] = b;
         else if (pos >= 18 && pos < 22) img_w[8*(pos-18) +: 8] = b;
         else if (pos >= 22 && pos < 26) img_h[8*(pos-22) +: 8] = b;
         else if (pos >= 28 && pos < 30) bits_pp[8*(pos-28) +: 8] = b;
         if (pos == HDR_BYTES - 1) begin
            if (sig_seen != BMP_SIGNATURE) begin
               batch[0] = '{KIND_BAD_SIG, 10'd0, 11'd0, 1'b0, 1'b0};
               n = 1;
               hdr_phase = PH_DONE;
            end else if ((!img_w[31] && img_w > MAX_WIDTH) ||
                         (!img_h[31] && img_h > MAX_HEIGHT)) begin
               batch[0] = '{KIND_TOO_BIG, 10'd0, 11'd0, 1'b0, 1'b0};
               n = 1;
               hdr_phase = PH_DONE;
            end else if (img_w[31] || img_h[31] || img_w == 0 || img_h == 0 ||
                         bits_pp != 16'd1) begin
               hdr_phase = PH_DONE;
            end else begin
               hdr_phase = PH_SKIP;
               row_byte = 13'd0;
               img_row = 11'(img_h - 1);
            end
         end
      end else if (hdr_phase == PH_SKIP || hdr_phase == PH_PIXELS) begin
         if (hdr_phase == PH_SKIP && pos >= data_start) hdr_phase = PH_PIXELS;
         if (hdr_phase == PH_PIXELS) begin
            row_len = ((img_w + 31) / 32) * 4;
            yv = {1'b0, bar_height} + img_row;
            for (k = 0; k < 8; k++) begin
               col = {16'd0, row_byte, 3'd0} + 32'(k);
               if (col < img_w) begin
                  batch[n] = '{KIND_PIXEL, col[9:0], yv, b[7-k], 1'b0};
                  n++;
               end
            end
            row_byte = row_byte + 13'd1;
            if ({19'd0, row_byte} >= row_len) begin
               row_byte = 13'd0;
               if (img_row == 11'd0) hdr_phase = PH_DONE;
               else img_row = img_row - 11'd1;
            end
         end
      end
      if (n > 0) batch[n-1].last = 1'b1;
      if (keep) begin
         for (k = 0; k < n; k++) decoded_queue.push_back(batch[k]);
      end
      return n;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endfunction

   function automatic int image_len(input logic [31:0] offs, input logic [31:0] wid,
                                    input logic [31:0] hgt);
      return ((offs > 30) ? int'(offs) - 30 : 0) + int'(((wid + 31) / 32) * 4 * hgt);
   endfunction

   // Input, register and result monitor; the predictor runs on every accepted byte.
   always @(posedge clock) begin
      if (!reset) begin
         if (push && !full) begin
            if (req_file_start || hdr_phase != PH_DONE) bytes_parsed++;
            if (byte_typed) begin
               void'(decode_file_byte(req_data_byte, req_file_start, 1'b0));
               decoded_queue.push_back('{typed_kind, 10'd0, 11'd0, 1'b0, 1'b1});
            end else begin
               void'(decode_file_byte(req_data_byte, req_file_start, 1'b1));
            end
         end
         if (psel && penable && pready) begin
            if (pwrite) begin
               if (paddr == CSR_STATUS_BAR) bar_height = pwdata[9:0];
            end else begin
               check_field("row offset register", {22'd0, bar_height}, prdata);
            end
         end
         if (pop && !empty) begin
            if (decoded_queue.size() == 0) begin
               $error("unexpected transaction: kind %0d x %0d y %0d", rsp_kind, rsp_pixel_x,
                      rsp_pixel_y);
               fail_count++;
            end else begin
               want_px = decoded_queue.pop_front();
               check_field("kind", 32'(want_px.kind), 32'(rsp_kind));
               check_field("pixel_x", 32'(want_px.x), 32'(rsp_pixel_x));
               check_field("pixel_y", 32'(want_px.y), 32'(rsp_pixel_y));
               check_field("pixel_white", 32'(want_px.white), 32'(rsp_pixel_white));
               check_field("last", 32'(want_px.last), 32'(rsp_last));
               transactions_checked++;
            end
         end
      end
   end

   // The receiver cycles through steady, random, sparse and long-stall patterns.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      case (cycle_count[8:7])
         2'd0: begin
            pop <= 1'b1;
         end
         2'd1: begin
            pop <= ($urandom_range(0, 3) != 0);
         end
         2'd2: begin
            pop <= (cycle_count[2:0] == 3'd0);
         end
         default: begin
            pop <= (cycle_count[4:0] > 5'd20);
         end
      endcase
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d transactions outstanding.",
                  cycle_count, decoded_queue.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic push_byte(input logic [7:0] b, input logic start, input bit typed,
                            input kind_type tkind);
      int gap;
      push <= 1'b1;
      push_level = 1'b1;
      req_data_byte <= b;
      req_file_start <= start;
      byte_typed <= typed;
      typed_kind <= tkind;
      @(posedge clock);
      while (full) @(posedge clock);
      if (!steady_sender) begin
         if (burst_left > 0) begin
            burst_left--;
         end else begin
            burst_left = $urandom_range(0, 15);
            gap = $urandom_range(1, 6);
            push <= 1'b0;
            push_level = 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic send_file(input file_row_type f, input bit steady);
      logic [7:0] hdr [30];
      int         nb;
      int         j;
      steady_sender = steady;
      for (j = 0; j < 30; j++) hdr[j] = 8'($urandom);
      hdr[0] = f.sig[7:0];
      hdr[1] = f.sig[15:8];
      for (j = 0; j < 4; j++) begin
         hdr[OFFSET_POS+j] = f.offs[8*j +: 8];
         hdr[WIDTH_POS+j]  = f.wid[8*j +: 8];
         hdr[HEIGHT_POS+j] = f.hgt[8*j +: 8];
      end
      hdr[DEPTH_POS]   = f.dep[7:0];
      hdr[DEPTH_POS+1] = f.dep[15:8];
      nb = (f.body < 0) ? image_len(f.offs, f.wid, f.hgt) : f.body;
      for (j = 0; j < f.hdr_len; j++) begin
         push_byte(hdr[j], (j == 0) ? f.start0 : 1'b0, f.typed && j == HDR_BYTES - 1, f.kind);
      end
      for (j = 0; j < nb; j++) begin
         push_byte((j % 4 == 0) ? 8'hFF : (j % 4 == 1) ? 8'h00 : 8'($urandom), 1'b0, 1'b0,
                   KIND_PIXEL);
      end
      files_sent++;
   endtask

   // Back-to-back write and read-back of one register.
   task automatic csr_write_check(input logic [2:0] addr, input logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      settings_used++;
   endtask

   task automatic drain;
      if (push_level) begin
         push <= 1'b0;
         push_level = 1'b0;
      end
      while (decoded_queue.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      file_row_type f;
      logic [31:0]  bar_word;
      int           phase;
      int           start_count;
      int           r;
      int           nb;
      int           i;
      directed_files[0]  = '{16'h4D42, 32'd62, 32'd9, 32'd2, 16'd1, 30, -1, 1'b0, 1'b0,
                             KIND_PIXEL};
      directed_files[1]  = '{16'h4D43, 32'd30, 32'd8, 32'd1, 16'd1, 30, 4, 1'b1, 1'b1,
                             KIND_BAD_SIG};
      directed_files[2]  = '{16'h4D42, 32'd30, 32'd1025, 32'd1, 16'd1, 30, 2, 1'b1, 1'b1,
                             KIND_TOO_BIG};
      directed_files[3]  = '{16'h4D42, 32'd30, 32'd8, 32'd1025, 16'd1, 30, 2, 1'b1, 1'b1,
                             KIND_TOO_BIG};
      directed_files[4]  = '{16'h0000, 32'd30, 32'd2000, 32'd1, 16'd1, 30, 2, 1'b1, 1'b1,
                             KIND_BAD_SIG};
      directed_files[5]  = '{16'h4D42, 32'd30, 32'd0, 32'd4, 16'd1, 30, 4, 1'b1, 1'b0,
                             KIND_PIXEL};
      directed_files[6]  = '{16'h4D42, 32'd30, 32'd8, 32'd0, 16'd1, 30, 4, 1'b1, 1'b0,
                             KIND_PIXEL};
      directed_files[7]  = '{16'h4D42, 32'd30, 32'hFFFF_FFF8, 32'd4, 16'd1, 30, 4, 1'b1,
                             1'b0, KIND_PIXEL};
      directed_files[8]  = '{16'h4D42, 32'd30, 32'd2000, 32'h8000_0000, 16'd1, 30, 2, 1'b1,
                             1'b1, KIND_TOO_BIG};
      directed_files[9]  = '{16'h4D42, 32'd30, 32'd16, 32'd2, 16'd24, 30, 8, 1'b1, 1'b0,
                             KIND_PIXEL};
      directed_files[10] = '{16'h4D42, 32'd10, 32'd33, 32'd1, 16'd1, 30, -1, 1'b1, 1'b0,
                             KIND_PIXEL};
      directed_files[11] = '{16'h4D42, 32'd30, 32'd1024, 32'd1, 16'd1, 30, -1, 1'b1, 1'b0,
                             KIND_PIXEL};
      directed_files[12] = '{16'h4D42, 32'd30, 32'd1, 32'd1024, 16'd1, 30, 12, 1'b1, 1'b0,
                             KIND_PIXEL};
      directed_files[13] = '{16'h4D42, 32'd30, 32'd8, 32'd1, 16'd1, 15, 0, 1'b1, 1'b0,
                             KIND_PIXEL};
      directed_files[14] = '{16'h4D42, 32'd30, 32'd8, 32'd1, 16'h0101, 30, 4, 1'b1, 1'b0,
                             KIND_PIXEL};
      directed_files[15] = '{16'h4D42, 32'd31, 32'd7, 32'd1, 16'd1, 30, -1, 1'b1, 1'b0,
                             KIND_PIXEL};

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      csr_write_check(CSR_STATUS_BAR, 32'hFFFF_FFFF);
      for (i = 0; i < N_DIRECTED; i++) send_file(directed_files[i], i % 3 == 0);

      for (phase = 0; phase < 5; phase++) begin
         drain();
         case (phase)
            0: bar_word = 32'h0000_0000;
            3: bar_word = 32'hFFFF_FC00;
            4: bar_word = 32'h0000_03FF;
            default: bar_word = $urandom;
         endcase
         csr_write_check(CSR_STATUS_BAR, bar_word);
         start_count = bytes_parsed;
         while (bytes_parsed - start_count < PHASE_BYTES) begin
            r = $urandom_range(0, 99);
            f.sig = (r < 6) ? 16'($urandom) : BMP_SIGNATURE;
            r = $urandom_range(0, 99);
            if (r < 78) f.wid = $urandom_range(1, 40);
            else if (r < 86) f.wid = $urandom_range(41, MAX_WIDTH);
            else if (r < 91) f.wid = $urandom_range(MAX_WIDTH + 1, 4096);
            else if (r < 95) f.wid = 32'd0;
            else f.wid = $urandom | 32'h8000_0000;
            r = $urandom_range(0, 99);
            if (r < 80) f.hgt = $urandom_range(1, 3);
            else if (r < 85) f.hgt = $urandom_range(4, MAX_HEIGHT);
            else if (r < 90) f.hgt = $urandom_range(MAX_HEIGHT + 1, 4096);
            else if (r < 95) f.hgt = 32'd0;
            else f.hgt = $urandom | 32'h8000_0000;
            r = $urandom_range(0, 99);
            if (r < 70) f.offs = 30 + $urandom_range(0, 12);
            else if (r < 85) f.offs = $urandom_range(0, 29);
            else f.offs = $urandom_range(31, 80);
            f.dep = ($urandom_range(0, 99) < 90) ? 16'd1 : 16'($urandom);
            f.hdr_len = ($urandom_range(0, 99) < 5) ? $urandom_range(1, 29) : HDR_BYTES;
            f.start0 = ($urandom_range(0, 99) < 95);
            f.typed = 1'b0;
            f.kind = KIND_PIXEL;
            if (f.sig == BMP_SIGNATURE && f.dep == 16'd1 && f.wid >= 1 &&
                f.wid <= MAX_WIDTH && f.hgt >= 1 && f.hgt <= MAX_HEIGHT) begin
               nb = image_len(f.offs, f.wid, f.hgt);
               if (nb > 48) nb = 48;
               if ($urandom_range(0, 9) == 0) nb = $urandom_range(0, nb);
            end else begin
               nb = $urandom_range(0, 6);
            end
            f.body = (f.hdr_len < HDR_BYTES) ? 0 : nb + $urandom_range(0, 3);
            send_file(f, $urandom_range(0, 3) == 0);
         end
      end
      drain();

      if (decoded_queue.size() != 0) begin
         $error("%0d expected transactions never arrived", decoded_queue.size());
         fail_count++;
      end
      $display("Sent %0d files (%0d bytes parsed) under %0d status bar settings.",
               files_sent, bytes_parsed, settings_used);
      $display("Checked %0d result transactions; %0d mismatches.",
               transactions_checked, fail_count);
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
